// ----- src/psq_pkg.sv -----
// ----------------------------------------------------------------------------
// Palindrome substring query: shared package
// Field widths, default depth, op codes and controller states.
// ----------------------------------------------------------------------------
package psq_pkg;

	localparam int unsigned POS_W       = 11;
	localparam int unsigned CH_W        = 8;
	localparam int unsigned DEF_MAX_LEN = 1024;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_RESULT
	} state_t;

endpackage

// ----- src/palindrome_substring_query_top.sv -----
// ----------------------------------------------------------------------------
// Palindrome substring query: top level
// Clear and append beats finish in the accept cycle. A query with pairs to check
// goes IDLE, RUN, DRAIN, RESULT, with one mirrored pair read per cycle from the
// two-read-port store; its result is loaded into the output register from RESULT.
// Single-character and out-of-range queries go from IDLE straight to RESULT.
// A full output register under stall holds the query in RESULT. Reset clears
// length, controller, read-valid pipe, mismatch flag and output valid only.
// ----------------------------------------------------------------------------
module palindrome_substring_query_top #(
	parameter int unsigned MAX_LEN = psq_pkg::DEF_MAX_LEN
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  psq_pkg::op_t              op,
	input  logic [psq_pkg::CH_W-1:0]  ch,
	input  logic [psq_pkg::POS_W-1:0] left_pos,
	input  logic [psq_pkg::POS_W-1:0] right_pos,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      is_palindrome
);
	import psq_pkg::*;

	// address, length and common compare widths
	localparam int unsigned AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
	localparam int unsigned CW    = (LEN_W > POS_W) ? LEN_W : POS_W;

	state_t            state_q, state_d;
	logic [LEN_W-1:0]  len_q;
	logic [AW-1:0]     lo_q, hi_q;
	logic              mismatch_q;
	logic              valid_s1;
	logic              out_valid_q;
	logic              is_pal_q;

	logic              accept;
	logic              rd_en;
	logic              load_res;
	logic              wr_en;
	logic              len_not_full;
	logic [CH_W-1:0]   rd_a, rd_b;
	logic [CW-1:0]     lp_x, rp_x, len_x;
	logic              q_ok, q_single;
	logic [AW-1:0]     lo_start, hi_start;
	logic [AW-1:0]     span;
	logic              last_pair;
	logic              cmp_fail;
	logic              out_free;

	// ------------------------------------------------------------------
	// Input side: only idle takes a beat. Clear and append finish in the
	// accept cycle, so the controller never leaves idle for them.
	// ------------------------------------------------------------------
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	assign len_not_full = (len_q < LEN_W'(MAX_LEN));
	assign wr_en        = accept && (op == OP_APPEND) && len_not_full;

	// Query range check in one common width so either side may be wider.
	assign lp_x     = CW'(left_pos);
	assign rp_x     = CW'(right_pos);
	assign len_x    = CW'(len_q);
	assign q_ok     = (lp_x != '0) && (lp_x <= rp_x) && (rp_x <= len_x);
	assign q_single = (lp_x == rp_x);
	// 0-based ends; only used when q_ok, so both lie below MAX_LEN
	assign lo_start = AW'(lp_x - CW'(1));
	assign hi_start = AW'(rp_x - CW'(1));

	// Pair walk: the current pair is the last when the ends are at most
	// two apart (they meet or cross after this step).
	assign span      = hi_q - lo_q;
	assign last_pair = ({1'b0, span} <= (AW + 1)'(2));

	// Compare stage sees the registered read data in the cycle after issue.
	assign cmp_fail = valid_s1 && (rd_a != rd_b);

	// Output register frees when empty or when the held beat leaves now.
	assign out_free = !out_valid_q || !out_stall;

	psq_store #(
		.MAX_LEN (MAX_LEN)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (len_q[AW-1:0]),
		.wr_data   (ch),
		.rd_en     (rd_en),
		.rd_addr_a (lo_q),
		.rd_addr_b (hi_q),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	// ------------------------------------------------------------------
	// Controller
	//   IDLE   : take a beat; a query with pairs to check goes to RUN,
	//            a trivial or out-of-range query goes straight to RESULT
	//   RUN    : issue one mirrored pair read per cycle
	//   DRAIN  : last pair's data is compared
	//   RESULT : hand the answer to the output register when it is free
	// Writes happen only in IDLE and reads only in RUN, so the store
	// never sees a read and a write of the same entry together.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		load_res = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (op == OP_QUERY)) begin
					if (q_ok && !q_single) begin
						state_d = S_RUN;
					end else begin
						state_d = S_RESULT;
					end
				end
			end
			S_RUN: begin
				rd_en = 1'b1;
				if (last_pair) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					load_res = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// String length: clear empties, append grows until full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (accept) begin
			case (op)
				OP_CLEAR:  len_q <= '0;
				OP_APPEND: if (len_not_full) begin
					len_q <= len_q + LEN_W'(1);
				end
				default:   len_q <= len_q;
			endcase
		end
	end

	// Pair pointers walk inward one step per issued read.
	always_ff @(posedge clk) begin
		if (accept && (op == OP_QUERY)) begin
			lo_q <= lo_start;
			hi_q <= hi_start;
		end else if (rd_en) begin
			lo_q <= lo_q + AW'(1);
			hi_q <= hi_q - AW'(1);
		end
	end

	// Read-valid pipe and sticky mismatch. An out-of-range query starts
	// with the mismatch set, so it answers no without any reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			mismatch_q <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			if (accept && (op == OP_QUERY)) begin
				mismatch_q <= !q_ok;
			end else if (cmp_fail) begin
				mismatch_q <= 1'b1;
			end
		end
	end

	// Output register: holds a result beat while the far side stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			is_pal_q <= !mismatch_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_palindrome = is_pal_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_run_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (lo_q < hi_q))
		else $error("pair pointers crossed while reading");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_LEN))
		else $error("string length past capacity");

	a_read_origin: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(state_q == S_RUN))
		else $error("read data valid without a read issued");

	a_result_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && (state_q == S_RESULT)) |=> (state_q == S_RESULT))
		else $error("result left while output slot held");

endmodule

// ----- src/psq_store.sv -----
// ----------------------------------------------------------------------------
// Palindrome substring query: character store
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module psq_store #(
	parameter  int unsigned MAX_LEN = psq_pkg::DEF_MAX_LEN,
	localparam int unsigned AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [psq_pkg::CH_W-1:0]  wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr_a,
	input  logic [AW-1:0]             rd_addr_b,
	output logic [psq_pkg::CH_W-1:0]  rd_data_a,
	output logic [psq_pkg::CH_W-1:0]  rd_data_b
);
	import psq_pkg::*;

	logic [CH_W-1:0] mem [MAX_LEN];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// ----- tb/palindrome_substring_query_top_tb.sv -----
// ----------------------------------------------------------------------------
// Palindrome substring query: testbench
// Loads byte strings one beat at a time through clear and append beats, then
// asks whether substrings read the same reversed. An in-bench mirror of the
// string predicts each answer, and results are checked in order against it.
// The sender works in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module palindrome_substring_query_top_tb;
	import psq_pkg::*;

	// one pending answer, with the span that asked for it
	typedef struct {
		logic [POS_W-1:0] lp;
		logic [POS_W-1:0] rp;
		bit               want;
	} answer_t;

	// Keeps its own copy of the string and the queue of answers still owed.
	class span_oracle;
		logic [CH_W-1:0] text [DEF_MAX_LEN];
		int unsigned     text_len;
		answer_t         answers_due [$];
		int unsigned     faults;

		function new();
			text_len = 0;
			faults   = 0;
		endfunction

		// walk inward from both ends of the span, 1-based inclusive positions
		function bit mirror_match(int unsigned lp, int unsigned rp);
			int unsigned lo;
			int unsigned hi;
			if (lp < 1 || lp > rp || rp > text_len)
				return 1'b0;
			lo = lp - 1;
			hi = rp - 1;
			while (lo < hi) begin
				if (text[lo] != text[hi])
					return 1'b0;
				lo++;
				hi--;
			end
			return 1'b1;
		endfunction

		function void flag(string msg);
			faults++;
			if (faults <= 10)
				$display("[%0t] mismatch: %s", $time, msg);
		endfunction

		function void note_beat(op_t o, logic [CH_W-1:0] c, logic [POS_W-1:0] lp,
				logic [POS_W-1:0] rp);
			answer_t a;
			case (o)
				OP_CLEAR: begin
					text_len = 0;
				end
				OP_APPEND: begin
					if (text_len < DEF_MAX_LEN) begin
						text[text_len] = c;
						text_len++;
					end
				end
				OP_QUERY: begin
					a.lp   = lp;
					a.rp   = rp;
					a.want = mirror_match(lp, rp);
					answers_due = {answers_due, a};
				end
				default: ;
			endcase
		endfunction

		function void check_answer(logic got);
			answer_t a;
			if (answers_due.size() == 0) begin
				flag($sformatf("result with no query pending, is_palindrome=%b", got));
				return;
			end
			a = answers_due.pop_front();
			if (got !== a.want)
				flag($sformatf("span %0d..%0d expected is_palindrome=%b, got %b",
					a.lp, a.rp, a.want, got));
		endfunction

		function void close();
			if (answers_due.size() != 0)
				flag($sformatf("%0d answers never arrived", answers_due.size()));
		endfunction
	endclass

	localparam int unsigned DEPTH        = DEF_MAX_LEN;
	localparam int unsigned ITEMS        = 1170;
	// closing stretch: clear, full fill, dropped appends, queries, clear, query
	localparam int unsigned FILL_ITEMS   = DEPTH + 23;
	localparam int unsigned RAND_END     = ITEMS - FILL_ITEMS;
	// slowest beat is a full-depth query plus a sender gap and a
	// receiver stall; the limit is several times that
	localparam int unsigned QUIET_LIMIT  = 5000;
	localparam int unsigned DRAIN_CYCLES = DEPTH / 2 + 16;
	localparam int unsigned POS_MAX      = 2 ** POS_W - 1;
	localparam op_t         OP_UNUSED    = op_t'(2'b11);

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	op_t              op        = OP_CLEAR;
	logic [CH_W-1:0]  ch        = '0;
	logic [POS_W-1:0] left_pos  = '0;
	logic [POS_W-1:0] right_pos = '0;
	logic             out_stall = 1'b0;
	logic             in_stall;
	logic             out_valid;
	logic             is_palindrome;

	span_oracle board = new();

	// string being built for the next run of append beats
	logic [CH_W-1:0] word [DEPTH];

	// sender burst bookkeeping: beats left before the next gap
	int unsigned burst_left = 0;
	// input beats accepted so far
	int unsigned beats_sent = 0;

	// receiver stall pattern state
	int unsigned seg_left   = 0;
	int unsigned stall_mode = 0;

	int unsigned quiet      = 0;

	palindrome_substring_query_top #(
		.MAX_LEN(DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.ch           (ch),
		.left_pos     (left_pos),
		.right_pos    (right_pos),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_palindrome(is_palindrome)
	);

	always #5 clk = ~clk;

	// Receiver stall pattern: switches between segments of random length.
	// Modes: never stall, coin flip, stall one time in four, and long holds
	// that stall for three quarters of each period, so results land on every phase of the stall pattern.
	always @(posedge clk) begin
		if (seg_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			seg_left   <= $urandom_range(20, 200);
		end else begin
			seg_left <= seg_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= 1'($urandom_range(0, 1));
			2: out_stall <= (seg_left % 4) == 0;
			default: out_stall <= (seg_left % 16) < 12;
		endcase
	end

	// result monitor: every accepted result beat is checked in order
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0)
			board.check_answer(is_palindrome);
	end

	// watchdog: ends the run if no beat moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("watchdog: no beat moved in %0d cycles", QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// Drive one input beat and hold it until accepted. Valid stays high into
	// the next beat unless this beat closes a burst; then a random gap follows.
	task automatic send_beat(input op_t o, input logic [CH_W-1:0] c,
			input logic [POS_W-1:0] l, input logic [POS_W-1:0] r);
		in_valid  <= 1'b1;
		op        <= o;
		ch        <= c;
		left_pos  <= l;
		right_pos <= r;
		do @(posedge clk); while (in_stall !== 1'b0);
		board.note_beat(o, c, l, r);
		beats_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			// mostly short bursts, now and then a long unbroken stretch
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic append(input logic [CH_W-1:0] c);
		send_beat(OP_APPEND, c, POS_W'($urandom), POS_W'($urandom));
	endtask

	task automatic query(input int unsigned l, input int unsigned r);
		send_beat(OP_QUERY, CH_W'($urandom), POS_W'(l), POS_W'(r));
	endtask

	// Choose a query span against the current length. Most spans are centered
	// on a random character so that palindromes are hit often; the rest are
	// plain in-range spans and odd spans, most of which must answer no.
	task automatic pick_query(output int unsigned l, output int unsigned r);
		int unsigned n;
		int unsigned kind;
		int unsigned c;
		int unsigned even;
		int unsigned reach;
		int unsigned rad;
		n    = board.text_len;
		kind = $urandom_range(0, 9);
		if (n == 0 && kind < 8)
			kind = 8;
		if (kind < 6) begin
			c     = $urandom_range(0, n - 1);
			even  = (c < n - 1) ? $urandom_range(0, 1) : 0;
			reach = (c < n - 1 - c - even) ? c : n - 1 - c - even;
			rad   = $urandom_range(0, reach);
			l     = c - rad + 1;
			r     = c + rad + even + 1;
		end else if (kind < 8) begin
			l = $urandom_range(1, n);
			r = $urandom_range(l, n);
		end else begin
			case ($urandom_range(0, 3))
				0: begin           // zero left position
					l = 0;
					r = $urandom_range(0, n);
				end
				1: begin           // left past right
					r = $urandom_range(0, n);
					l = r + 1 + $urandom_range(0, 3);
				end
				2: begin           // right past the stored length
					r = n + 1 + $urandom_range(0, 5);
					l = $urandom_range(1, r);
				end
				default: begin     // anything the 11-bit fields can carry
					l = $urandom_range(0, POS_MAX);
					r = $urandom_range(0, POS_MAX);
				end
			endcase
		end
	endtask

	initial begin
		int unsigned len;
		int unsigned style;
		int unsigned nq;
		int unsigned ql;
		int unsigned qr;
		logic [CH_W-1:0] sym_a;
		logic [CH_W-1:0] sym_b;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		query(1, 1);                       // empty string answers no
		query(0, 0);                       // zero left on an empty string
		send_beat(OP_UNUSED, 8'hFF, POS_W'(POS_MAX), POS_W'(POS_MAX));
		append(8'h00);
		query(1, 1);                       // single character
		append(8'hFF);
		append(8'h00);
		query(1, 3);                       // odd palindrome 00 FF 00
		query(1, 2);
		query(3, 1);                       // left past right
		query(0, 3);                       // zero left position
		query(2, 4);                       // right past length
		query(POS_MAX, POS_MAX);
		append(8'hFF);
		query(1, 4);
		query(2, 3);
		send_beat(OP_CLEAR, 8'h00, '0, '0);
		query(1, 1);                       // nothing left after a clear
		append(8'h5A);
		append(8'h5A);
		query(1, 2);                       // even palindrome

		// ---- random part: clear, build a string, then a run of queries ----
		while (beats_sent < RAND_END) begin
			// now and then keep the old string and append onto it
			if ($urandom_range(0, 6) != 0) begin
				send_beat(OP_CLEAR, CH_W'($urandom), POS_W'($urandom), POS_W'($urandom));
			end
			len   = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 24)
				: $urandom_range(25, 300);
			// keep the whole run near the beat budget
			if (len > RAND_END - beats_sent)
				len = RAND_END - beats_sent;
			style = $urandom_range(0, 2);
			sym_a = CH_W'($urandom);
			sym_b = CH_W'($urandom);
			// two-symbol strings, mirrored strings, or plain random bytes
			for (int i = 0; i < len; i++) begin
				case (style)
					0: word[i] = $urandom_range(0, 1) ? sym_a : sym_b;
					1: word[i] = (i < (len + 1) / 2) ? CH_W'($urandom) : word[len - 1 - i];
					default: word[i] = CH_W'($urandom);
				endcase
			end
			// spoil a mirrored string half the time
			if (style == 1 && len > 0 && $urandom_range(0, 1))
				word[$urandom_range(0, len - 1)] = CH_W'($urandom);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 19) == 0)
					send_beat(OP_UNUSED, CH_W'($urandom), POS_W'($urandom), POS_W'($urandom));
				append(word[i]);
			end
			nq = $urandom_range(1, 12);
			for (int i = 0; i < nq; i++) begin
				pick_query(ql, qr);
				query(ql, qr);
			end
		end

		// ---- fill to capacity with a full-length palindrome ----
		send_beat(OP_CLEAR, 8'h00, '0, '0);
		for (int i = 0; i < DEPTH; i++) begin
			word[i] = (i < DEPTH / 2) ? CH_W'($urandom) : word[DEPTH - 1 - i];
			append(word[i]);
		end
		// appends when full are dropped and must not disturb the string
		repeat (3) append(CH_W'($urandom));
		query(1, DEPTH);
		query(1, DEPTH + 1);
		query(DEPTH, DEPTH);
		query(DEPTH / 2, DEPTH / 2 + 1);
		query(2, DEPTH - 1);
		query(1, DEPTH - 1);
		query(DEPTH, POS_MAX);
		for (int i = 0; i < 10; i++) begin
			pick_query(ql, qr);
			query(ql, qr);
		end
		send_beat(OP_CLEAR, 8'h00, '0, '0);
		query(1, DEPTH);

		// ---- wind down ----
		in_valid <= 1'b0;
		while (board.answers_due.size() != 0)
			@(posedge clk);
		// catch any stray result after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		board.close();
		if (board.faults == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
src/psq_pkg.sv
src/psq_store.sv
src/palindrome_substring_query_top.sv
tb/palindrome_substring_query_top_tb.sv
